[design/dwfn_pkg.sv]
// Package for the word-format normalizer: beat types, command format passed
// from the front end to the back end, sync-word reset values and helpers.
// No dependencies.
package dwfn_pkg;

	localparam int NUM_SYNC = 6;
	localparam int PADDR_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int GROUP_PAIRS = 8;
	localparam int GROUP_WORDS = 7;
	localparam logic [13:0] MASK14 = 14'h3fff;

	typedef logic [1:0] fmt_t;
	localparam fmt_t FMT_BE16 = 2'd0;
	localparam fmt_t FMT_LE16 = 2'd1;
	localparam fmt_t FMT_BE14 = 2'd2;
	localparam fmt_t FMT_LE14 = 2'd3;

	localparam logic [1:0] BV_NONE = 2'd0;
	localparam logic [1:0] BV_ONE = 2'd1;
	localparam logic [1:0] BV_TWO = 2'd2;

	localparam logic ST_OK = 1'b0;
	localparam logic ST_NOSYNC = 1'b1;

	typedef logic [13:0] sample_t;
	typedef logic [NUM_SYNC-1:0][31:0] sync_regs_t;

	localparam sync_regs_t SYNC_RESET = {
		32'hFF1F00E8, 32'h1FFFE800, 32'h58642520,
		32'hFE7F0180, 32'h64582025, 32'h7FFE8001
	};
	localparam logic [NUM_SYNC-1:0][1:0] SYNC_FMT = {
		FMT_LE14, FMT_BE14, FMT_LE16, FMT_LE16, FMT_BE16, FMT_BE16
	};

	typedef struct packed {
		logic [15:0] data_pair;
		logic        frame_end;
	} item_t;

	typedef struct packed {
		logic [15:0] out_word;
		logic [1:0]  bytes_valid;
		fmt_t        format;
		logic        status;
		logic        last_of_run;
		logic        end_of_frame;
	} result_t;

	typedef enum logic [1:0] {
		CMD_NOSYNC = 2'd0,
		CMD_PASS   = 2'd1,
		CMD_PACK   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                          kind;
		fmt_t                               fmt;
		logic                               eof;
		logic [2:0]                         last_idx;
		logic                               half_last;
		logic [1:0][15:0]                   pass_word;
		logic [GROUP_PAIRS-1:0][13:0]       group;
	} cmd_t;

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

endpackage

[design/dwfn_regs.sv]
// Sync-word register file behind an APB-style write/read port.
// Depends on dwfn_pkg.
module dwfn_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dwfn_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output dwfn_pkg::sync_regs_t              sync
);

	dwfn_pkg::sync_regs_t sync_q;
	logic [dwfn_pkg::CFG_IDX_W-1:0] idx;
	logic wr;

	assign idx = paddr[dwfn_pkg::PADDR_W-1:2];
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	assign sync = sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= dwfn_pkg::SYNC_RESET;
		end else if (wr) begin
			for (int k = 0; k < dwfn_pkg::NUM_SYNC; k++) begin
				if (idx == dwfn_pkg::CFG_IDX_W'(k)) begin
					sync_q[k] <= pwdata;
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int k = 0; k < dwfn_pkg::NUM_SYNC; k++) begin
			if (idx == dwfn_pkg::CFG_IDX_W'(k)) begin
				prdata = sync_q[k];
			end
		end
	end

endmodule

[design/dwfn_front.sv]
// Front end: accepts input beats, matches the sync word, tracks the frame
// phase and 14-bit groups, and issues one command per beat that has output.
// Depends on dwfn_pkg.
module dwfn_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  dwfn_pkg::item_t        item,
	input  logic                   cmd_full,
	input  dwfn_pkg::sync_regs_t   sync,
	output logic                   cmd_push,
	output dwfn_pkg::cmd_t         cmd
);

	typedef enum logic [3:0] {
		PH_AWAIT  = 4'b0001,
		PH_HOLD   = 4'b0010,
		PH_STREAM = 4'b0100,
		PH_DROP   = 4'b1000
	} phase_t;

	phase_t phase_q, phase_d;
	logic [15:0] held_q;
	logic [2:0] cnt_q, cnt_d;
	dwfn_pkg::fmt_t fmt_q, fmt_d;
	logic [dwfn_pkg::GROUP_PAIRS-1:0][13:0] grp_q;

	logic accept;
	logic eof;
	logic [15:0] p;
	logic hit;
	dwfn_pkg::fmt_t hit_fmt;
	dwfn_pkg::sample_t v, vh, vp;
	logic [dwfn_pkg::GROUP_PAIRS-1:0][13:0] grp_next;
	logic cmd_valid;
	logic hold_write;
	logic stream_write;

	assign accept = push & ~cmd_full;
	assign p = item.data_pair;
	assign eof = item.frame_end;
	assign cmd_push = accept & cmd_valid;

	always_comb begin
		hit = 1'b0;
		hit_fmt = dwfn_pkg::FMT_BE16;
		for (int k = dwfn_pkg::NUM_SYNC - 1; k >= 0; k--) begin
			if (sync[k] == {held_q, p}) begin
				hit = 1'b1;
				hit_fmt = dwfn_pkg::SYNC_FMT[k];
			end
		end
	end

	always_comb begin
		v = ((fmt_q == dwfn_pkg::FMT_LE14) ? 14'(dwfn_pkg::swap16(p)) : p[13:0])
			& dwfn_pkg::MASK14;
		vh = ((hit_fmt == dwfn_pkg::FMT_LE14) ? 14'(dwfn_pkg::swap16(held_q))
			: held_q[13:0]) & dwfn_pkg::MASK14;
		vp = ((hit_fmt == dwfn_pkg::FMT_LE14) ? 14'(dwfn_pkg::swap16(p)) : p[13:0])
			& dwfn_pkg::MASK14;
		for (int j = 0; j < dwfn_pkg::GROUP_PAIRS; j++) begin
			if (3'(j) < cnt_q) begin
				grp_next[j] = grp_q[j];
			end else if (3'(j) == cnt_q) begin
				grp_next[j] = v;
			end else begin
				grp_next[j] = '0;
			end
		end
	end

	always_comb begin
		cmd = '0;
		cmd.kind = dwfn_pkg::CMD_NOSYNC;
		cmd.eof = eof;
		cmd_valid = 1'b0;
		hold_write = 1'b0;
		stream_write = 1'b0;
		phase_d = phase_q;
		cnt_d = cnt_q;
		fmt_d = fmt_q;
		case (phase_q)
			PH_AWAIT: begin
				cnt_d = '0;
				if (eof) begin
					cmd_valid = 1'b1;
				end else begin
					phase_d = PH_HOLD;
				end
			end
			PH_HOLD: begin
				if (!hit) begin
					cmd_valid = 1'b1;
					phase_d = eof ? PH_AWAIT : PH_DROP;
				end else begin
					fmt_d = hit_fmt;
					phase_d = eof ? PH_AWAIT : PH_STREAM;
					cmd.fmt = hit_fmt;
					if (hit_fmt inside {dwfn_pkg::FMT_BE16, dwfn_pkg::FMT_LE16}) begin
						cmd_valid = 1'b1;
						cmd.kind = dwfn_pkg::CMD_PASS;
						cmd.last_idx = 3'd1;
						cmd.pass_word[0] = (hit_fmt == dwfn_pkg::FMT_LE16) ?
							dwfn_pkg::swap16(held_q) : held_q;
						cmd.pass_word[1] = (hit_fmt == dwfn_pkg::FMT_LE16) ?
							dwfn_pkg::swap16(p) : p;
						cnt_d = '0;
					end else begin
						hold_write = 1'b1;
						cnt_d = eof ? 3'd0 : 3'd2;
						if (eof) begin
							cmd_valid = 1'b1;
							cmd.kind = dwfn_pkg::CMD_PACK;
							cmd.last_idx = 3'd1;
							cmd.group[0] = vh;
							cmd.group[1] = vp;
						end
					end
				end
			end
			PH_STREAM: begin
				if (eof) begin
					phase_d = PH_AWAIT;
				end
				cmd.fmt = fmt_q;
				if (fmt_q inside {dwfn_pkg::FMT_BE16, dwfn_pkg::FMT_LE16}) begin
					cmd_valid = 1'b1;
					cmd.kind = dwfn_pkg::CMD_PASS;
					cmd.pass_word[0] = (fmt_q == dwfn_pkg::FMT_LE16) ?
						dwfn_pkg::swap16(p) : p;
				end else begin
					stream_write = 1'b1;
					if (cnt_q == 3'(dwfn_pkg::GROUP_PAIRS - 1) || eof) begin
						cmd_valid = 1'b1;
						cmd.kind = dwfn_pkg::CMD_PACK;
						cmd.group = grp_next;
						if (cnt_q == 3'(dwfn_pkg::GROUP_PAIRS - 1)) begin
							cmd.last_idx = 3'(dwfn_pkg::GROUP_WORDS - 1);
						end else begin
							cmd.last_idx = cnt_q;
							cmd.half_last = (cnt_q >= 3'd3);
						end
						cnt_d = '0;
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
			end
			PH_DROP: begin
				if (eof) begin
					phase_d = PH_AWAIT;
				end
			end
			default: begin
				phase_d = PH_AWAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_AWAIT;
			held_q <= '0;
			cnt_q <= '0;
			fmt_q <= dwfn_pkg::FMT_BE16;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			fmt_q <= fmt_d;
			if (phase_q == PH_AWAIT) begin
				held_q <= p;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_write) begin
			grp_q[0] <= vh;
			grp_q[1] <= vp;
		end else if (accept && stream_write) begin
			grp_q[cnt_q] <= v;
		end
	end

endmodule

[design/dwfn_cmd_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on dwfn_pkg. DEPTH must be at least 2.
module dwfn_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dwfn_pkg::cmd_t  wr_cmd,
	output logic            full,
	input  logic            pop,
	output dwfn_pkg::cmd_t  rd_cmd,
	output logic            empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	dwfn_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

[design/dwfn_back.sv]
// Back end: steps through each command, one output word per cycle while
// the output register is free or popped; packs 14-bit groups or passes
// 16-bit words, holding the current result beat there. Depends on dwfn_pkg.
module dwfn_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  dwfn_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  logic              pop,
	output logic              empty,
	output dwfn_pkg::result_t result
);

	dwfn_pkg::cmd_t cmd_q;
	logic busy_q;
	logic [2:0] idx_q;
	logic out_valid_q;
	dwfn_pkg::result_t out_q;

	logic out_ready, emit, is_last;
	logic [2:0] nxt;
	logic [27:0] pair;
	logic [3:0] sh;
	dwfn_pkg::result_t res;

	assign out_ready = ~out_valid_q | pop;
	assign emit = busy_q & out_ready;
	assign is_last = (idx_q == cmd_q.last_idx);
	assign cmd_pop = ~cmd_empty & (~busy_q | (emit & is_last));
	assign empty = ~out_valid_q;
	assign result = out_q;
	assign nxt = idx_q + 3'd1;
	assign pair = {cmd_q.group[idx_q], cmd_q.group[nxt]};
	assign sh = 4'd12 - {idx_q, 1'b0};

	always_comb begin
		res = '0;
		res.last_of_run = is_last;
		res.end_of_frame = is_last & cmd_q.eof;
		case (cmd_q.kind)
			dwfn_pkg::CMD_PASS: begin
				res.out_word = cmd_q.pass_word[idx_q[0]];
				res.bytes_valid = dwfn_pkg::BV_TWO;
				res.format = cmd_q.fmt;
				res.status = dwfn_pkg::ST_OK;
			end
			dwfn_pkg::CMD_PACK: begin
				res.out_word = 16'(pair >> sh);
				res.bytes_valid = (is_last && cmd_q.half_last) ?
					dwfn_pkg::BV_ONE : dwfn_pkg::BV_TWO;
				res.format = cmd_q.fmt;
				res.status = dwfn_pkg::ST_OK;
			end
			default: begin
				res.out_word = '0;
				res.bytes_valid = dwfn_pkg::BV_NONE;
				res.format = dwfn_pkg::FMT_BE16;
				res.status = dwfn_pkg::ST_NOSYNC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (emit) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end
				idx_q <= nxt;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (emit) begin
			out_q <= res;
		end
	end

endmodule

[design/dts_word_format_normalizer.sv]
// Word-format normalizer top level. One input beat is taken per cycle while
// the command queue is not full; the back end emits one result beat per cycle
// while its output register is free or popped, so a full 14-bit group of
// eight beats yields seven result beats and a matched 16-bit sync pair two.
// Reset empties the queue, clears the frame phase and output valid flag and
// loads the default sync words; the 14-bit group store is not cleared.
module dts_word_format_normalizer #(
	parameter int CMD_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  dwfn_pkg::item_t                item,
	output logic                           empty,
	input  logic                           pop,
	output dwfn_pkg::result_t              result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dwfn_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	dwfn_pkg::sync_regs_t sync;
	dwfn_pkg::cmd_t wr_cmd, rd_cmd;
	logic cmd_push, cmd_pop, cmd_empty;

	dwfn_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sync    (sync)
	);

	dwfn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.cmd_full (full),
		.sync     (sync),
		.cmd_push (cmd_push),
		.cmd      (wr_cmd)
	);

	dwfn_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wr_cmd (wr_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rd_cmd (rd_cmd),
		.empty  (cmd_empty)
	);

	dwfn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (rd_cmd),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
